>>> sv/odq_pkg.sv
package odq_pkg;

	// obstacle flag codes
	localparam logic [1:0] FLAG_NONE      = 2'd0;
	localparam logic [1:0] FLAG_SUSPECTED = 2'd1;
	localparam logic [1:0] FLAG_CONFIRMED = 2'd2;

	// detection modes
	localparam logic [1:0] MODE_FORCED     = 2'd0;
	localparam logic [1:0] MODE_RANGE_PIX  = 2'd1;
	localparam logic [1:0] MODE_PIX_ONLY   = 2'd2;
	localparam logic [1:0] MODE_RANGE_ONLY = 2'd3;

	// range limits
	localparam logic [10:0] DIST_MAX  = 11'd1300;
	localparam logic [10:0] DIST_LOW  = 11'd100;
	localparam logic [10:0] DIST_HIGH = 11'd900;
	localparam logic [10:0] DIST_NEAR = 11'd800;

	localparam int unsigned HOLDOFF_TICKS = 1500;

	// steering error limits per chassis
	localparam logic signed [15:0] ERR_LIMIT_TWO   = 16'sd15;
	localparam logic signed [15:0] ERR_LIMIT_THREE = 16'sd20;

	// strong pixel limits per chassis
	localparam logic [11:0] STRONG_PIX_TWO   = 12'd80;
	localparam logic [11:0] STRONG_PIX_THREE = 12'd30;

	localparam logic [7:0] CNT_MAX = 8'd255;

	localparam int unsigned ADDR_BITS = 6;
	localparam int unsigned DATA_BITS = 64;

	typedef enum logic [2:0] {
		REG_DETECT_MODE   = 3'd0,
		REG_CHASSIS_KIND  = 3'd1,
		REG_PIXEL_THRESH  = 3'd2,
		REG_CONFIRM_COUNT = 3'd3,
		REG_FORCED_TICK   = 3'd4,
		REG_WINDOW_ONE    = 3'd5,
		REG_WINDOW_TWO    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  detect_mode;
		logic        chassis_kind;
		logic [11:0] pixel_threshold;
		logic [7:0]  confirm_count;
		logic [23:0] forced_tick;
		logic [23:0] win1_lo;
		logic [23:0] win1_hi;
		logic [23:0] win2_lo;
		logic [23:0] win2_hi;
	} cfg_t;

endpackage

>>> sv/odq_regs.sv
module odq_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [odq_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [odq_pkg::DATA_BITS-1:0]      pwdata,
	output logic [odq_pkg::DATA_BITS-1:0]      prdata,
	output logic                               pready,
	output odq_pkg::cfg_t                      cfg
);

	odq_pkg::cfg_t    cfg_q;
	odq_pkg::reg_idx_t idx;
	logic             wr_en;

	// registers sit on 8-byte strides
	assign idx    = odq_pkg::reg_idx_t'(paddr[odq_pkg::ADDR_BITS-1:3]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_mode     <= odq_pkg::MODE_FORCED;
			cfg_q.chassis_kind    <= 1'b0;
			cfg_q.pixel_threshold <= 12'd40;
			cfg_q.confirm_count   <= 8'd2;
			cfg_q.forced_tick     <= 24'd15000;
			cfg_q.win1_lo         <= '0;
			cfg_q.win1_hi         <= '0;
			cfg_q.win2_lo         <= '0;
			cfg_q.win2_hi         <= '0;
		end else if (wr_en) begin
			unique case (idx)
				odq_pkg::REG_DETECT_MODE:   cfg_q.detect_mode     <= pwdata[1:0];
				odq_pkg::REG_CHASSIS_KIND:  cfg_q.chassis_kind    <= pwdata[0];
				odq_pkg::REG_PIXEL_THRESH:  cfg_q.pixel_threshold <= pwdata[11:0];
				odq_pkg::REG_CONFIRM_COUNT: cfg_q.confirm_count   <= pwdata[7:0];
				odq_pkg::REG_FORCED_TICK:   cfg_q.forced_tick     <= pwdata[23:0];
				odq_pkg::REG_WINDOW_ONE: begin
					cfg_q.win1_lo <= pwdata[23:0];
					cfg_q.win1_hi <= pwdata[47:24];
				end
				odq_pkg::REG_WINDOW_TWO: begin
					cfg_q.win2_lo <= pwdata[23:0];
					cfg_q.win2_hi <= pwdata[47:24];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			odq_pkg::REG_DETECT_MODE:   prdata[1:0]  = cfg_q.detect_mode;
			odq_pkg::REG_CHASSIS_KIND:  prdata[0]    = cfg_q.chassis_kind;
			odq_pkg::REG_PIXEL_THRESH:  prdata[11:0] = cfg_q.pixel_threshold;
			odq_pkg::REG_CONFIRM_COUNT: prdata[7:0]  = cfg_q.confirm_count;
			odq_pkg::REG_FORCED_TICK:   prdata[23:0] = cfg_q.forced_tick;
			odq_pkg::REG_WINDOW_ONE:    prdata[47:0] = {cfg_q.win1_hi, cfg_q.win1_lo};
			odq_pkg::REG_WINDOW_TWO:    prdata[47:0] = {cfg_q.win2_hi, cfg_q.win2_lo};
			default:                    prdata       = '0;
		endcase
	end

endmodule

>>> sv/obstacle_detect_qualifier.sv
// obstacle_detect_qualifier
//
// one request per control tick on the item channel (item_valid / item_stall)
// carries time, range, pixel count, steering error, roundabout and ramp stage
// and the current obstacle flag; one result per request leaves on the result
// channel (result_valid / result_stall) with the new flag and the clamped range
//
// result_valid rises once a request has passed an input register, then one
// pass of compares and the confirm counter update into the result register;
// throughput is one request per cycle while result_stall is low, as the
// confirm counter and last trigger tick update once per request
//
// when the receiver stalls, the result register holds and the input register
// may still take one more request; item_stall rises only when both are full
//
// reset clears both valid bits, the confirm counter and the last trigger tick,
// and loads the register defaults; the user must write registers through the
// apb-style port at byte address 8*i while no request is in flight (unchecked)
module obstacle_detect_qualifier #(
	parameter int unsigned TIME_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item channel
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [23:0]                        time_now,
	input  logic [15:0]                        distance_raw,
	input  logic [11:0]                        obstacle_pixels,
	input  logic signed [15:0]                 steering_error,
	input  logic [1:0]                         circle_state,
	input  logic [1:0]                         ramp_state,
	input  logic [1:0]                         obstacle_flag_in,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [1:0]                         obstacle_flag,
	output logic [10:0]                        distance_clamped,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [odq_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [odq_pkg::DATA_BITS-1:0]      pwdata,
	output logic [odq_pkg::DATA_BITS-1:0]      prdata,
	output logic                               pready
);

	// widen or cut a 24-bit tick value to the internal time width
	function automatic logic [TIME_BITS-1:0] to_time(input logic [23:0] v);
		logic [TIME_BITS+23:0] ext;
		ext = {{TIME_BITS{1'b0}}, v};
		return ext[TIME_BITS-1:0];
	endfunction

	odq_pkg::cfg_t cfg;

	odq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic                 valid_s1;
	logic [23:0]          time_s1;
	logic [15:0]          dist_s1;
	logic [11:0]          pix_s1;
	logic signed [15:0]   err_s1;
	logic [1:0]           circle_s1;
	logic [1:0]           ramp_s1;
	logic [1:0]           flag_s1;

	// result register
	logic                 valid_s2;
	logic [1:0]           flag_s2;
	logic [10:0]          dist_s2;

	// qualifier state
	logic [7:0]           cnt_q;
	logic [TIME_BITS-1:0] last_q;

	logic                 adv_s1;
	logic                 take_in;

	// the result register frees up when empty or being taken
	assign adv_s1     = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv_s1;
	assign take_in    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			time_s1   <= time_now;
			dist_s1   <= distance_raw;
			pix_s1    <= obstacle_pixels;
			err_s1    <= steering_error;
			circle_s1 <= circle_state;
			ramp_s1   <= ramp_state;
			flag_s1   <= obstacle_flag_in;
		end
	end

	// decision logic
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] since;
	logic [10:0]          dist_c;
	logic [1:0]           flag_c;
	logic                 three;
	logic signed [15:0]   err_lim;
	logic                 err_ok;
	logic                 hold_ok;
	logic                 win_ok;
	logic                 common;
	logic                 pix_ok;
	logic                 rng_ok;
	logic                 near;
	logic                 strong_pix;
	logic                 pass;
	logic                 confirm_ok;
	logic [1:0]           flag_nx;
	logic [7:0]           cnt_nx;
	logic                 trig;

	assign now    = to_time(time_s1);
	assign since  = now - last_q;
	assign dist_c = (dist_s1 > 16'(odq_pkg::DIST_MAX)) ? odq_pkg::DIST_MAX : dist_s1[10:0];
	// flag code 3 counts as confirmed
	assign flag_c = (flag_s1 == 2'd3) ? odq_pkg::FLAG_CONFIRMED : flag_s1;
	assign three  = cfg.chassis_kind;

	assign err_lim = three ? odq_pkg::ERR_LIMIT_THREE : odq_pkg::ERR_LIMIT_TWO;
	assign err_ok  = (err_s1 < err_lim) && (err_s1 > -err_lim);

	// holdoff after the last confirmation, zero means never
	assign hold_ok = (since > TIME_BITS'(odq_pkg::HOLDOFF_TICKS)) || (last_q == '0);

	assign win_ok = ((now > to_time(cfg.win1_lo)) && (now < to_time(cfg.win1_hi)))
		|| ((now > to_time(cfg.win2_lo)) && (now < to_time(cfg.win2_hi)));

	assign common = err_ok && hold_ok && win_ok
		&& (flag_c != odq_pkg::FLAG_CONFIRMED)
		&& !circle_s1[1] && (ramp_s1 != 2'd1);

	assign pix_ok     = pix_s1 > cfg.pixel_threshold;
	assign rng_ok     = (dist_c > odq_pkg::DIST_LOW) && (dist_c < odq_pkg::DIST_HIGH);
	assign near       = dist_c < odq_pkg::DIST_NEAR;
	assign strong_pix = pix_s1 > (three ? odq_pkg::STRONG_PIX_THREE : odq_pkg::STRONG_PIX_TWO);

	always_comb begin
		pass       = 1'b0;
		confirm_ok = 1'b0;
		case (cfg.detect_mode)
			odq_pkg::MODE_RANGE_PIX: begin
				pass       = common && rng_ok && pix_ok;
				confirm_ok = near || strong_pix;
			end
			odq_pkg::MODE_PIX_ONLY: begin
				pass       = common && pix_ok;
				confirm_ok = strong_pix;
			end
			odq_pkg::MODE_RANGE_ONLY: begin
				pass       = common && rng_ok;
				confirm_ok = near;
			end
			default: begin
				pass       = 1'b0;
				confirm_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		flag_nx = flag_c;
		cnt_nx  = cnt_q;
		trig    = 1'b0;
		if (cfg.detect_mode == odq_pkg::MODE_FORCED) begin
			// timed force leaves the counter and trigger tick alone
			if (now == to_time(cfg.forced_tick)) begin
				flag_nx = odq_pkg::FLAG_CONFIRMED;
			end
		end else if (pass) begin
			if (cnt_q != odq_pkg::CNT_MAX) begin
				cnt_nx = cnt_q + 8'd1;
			end
			flag_nx = odq_pkg::FLAG_SUSPECTED;
			// the confirm test sees the counter after this step
			if ((cnt_nx >= cfg.confirm_count) && confirm_ok) begin
				flag_nx = odq_pkg::FLAG_CONFIRMED;
				trig    = 1'b1;
			end
		end else if (cnt_q != 8'd0) begin
			cnt_nx = cnt_q - 8'd1;
		end else if (flag_c == odq_pkg::FLAG_SUSPECTED) begin
			// suspicion drained
			flag_nx = odq_pkg::FLAG_NONE;
		end
	end

	// state moves with the request that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else if (valid_s1 && adv_s1) begin
			cnt_q <= cnt_nx;
			if (trig) begin
				last_q <= now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			flag_s2 <= flag_nx;
			dist_s2 <= dist_c;
		end
	end

	assign result_valid     = valid_s2;
	assign obstacle_flag    = flag_s2;
	assign distance_clamped = dist_s2;

	// checks
	a_flag_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (obstacle_flag != 2'd3))
		else $error("obstacle flag out of range");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (distance_clamped <= odq_pkg::DIST_MAX))
		else $error("clamped distance out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("item stalled with room in the pipeline");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			((cnt_q == $past(cnt_q) + 8'd1) || (cnt_q == $past(cnt_q) - 8'd1)))
		else $error("confirm counter jumped");

	a_trig_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q != $past(last_q)) |->
			(result_valid && (obstacle_flag == odq_pkg::FLAG_CONFIRMED)))
		else $error("trigger tick moved without a confirmation");

endmodule
